@@ hdl/rc4_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_pkg
// Request and status codes for the RC4 keystream core.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int unsigned TableSize = 256;
  localparam int unsigned IdxW      = 8;

  typedef enum logic [1:0] {
    REQ_RESTART  = 2'd0,
    REQ_KEY      = 2'd1,
    REQ_KSTREAM  = 2'd2,
    REQ_READ     = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_SURPLUS   = 2'd2
  } status_e;

endpackage : rc4_pkg
`default_nettype wire

@@ hdl/rc4_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_ram
// Generic RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule : rc4_ram
`default_nettype wire

@@ hdl/rc4_keystream_generator_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_keystream_generator_core
// RC4 engine: key schedule, keystream generation and state readback.
// ----------------------------------------------------------------------------
// The 256-byte permutation lives in one RAM with a registered read port and
// is walked by a small sequencer, one RAM access a cycle. A read request
// passes through S_RD_X, a key byte through S_RD_J, S_WR_I, S_WR_J, and a
// keystream byte through those, S_RD_T and S_OUT_T. A keystream request
// before the schedule is done, or a surplus key byte, has its status
// registered on acceptance; so does restart, which then refills the table
// with identity, as after reset, taking no request. One request is in flight
// at a time; the next is taken once the last result is or is being taken.
module rc4_keystream_generator_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire rc4_pkg::req_type_e  req_type_i,
  input  wire logic [7:0]          key_byte_i,
  input  wire logic [7:0]          entry_index_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic [7:0]          out_byte_o,
  output      rc4_pkg::status_e    status_o
);

  import rc4_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FILL  = 3'd1;
  localparam logic [2:0] S_RD_J  = 3'd2;
  localparam logic [2:0] S_WR_I  = 3'd3;
  localparam logic [2:0] S_WR_J  = 3'd4;
  localparam logic [2:0] S_RD_T  = 3'd5;
  localparam logic [2:0] S_OUT_T = 3'd6;
  localparam logic [2:0] S_RD_X  = 3'd7;

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] i_q, i_d, j_q, j_d;
  logic [IdxW:0]   cnt_q, cnt_d;
  logic [IdxW-1:0] fill_q, fill_d;
  logic [IdxW-1:0] si_q, si_d, sj_q, sj_d, key_q, key_d;
  logic            is_key_q, is_key_d;
  logic            ov_q, ov_d;
  logic [7:0]      ob_q, ob_d;
  status_e         st_q, st_d;

  logic            we;
  logic [IdxW-1:0] waddr, wdata, raddr, rdata;
  logic [IdxW-1:0] j_new;
  logic            accept;

  rc4_ram #(
    .Width(IdxW),
    .Depth(TableSize)
  ) u_perm (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE) && (!ov_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign status_o    = st_q;

  assign j_new = j_q + rdata + (is_key_q ? key_q : '0);

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    j_d      = j_q;
    cnt_d    = cnt_q;
    fill_d   = fill_q;
    si_d     = si_q;
    sj_d     = sj_q;
    key_d    = key_q;
    is_key_d = is_key_q;
    ov_d     = ov_q && !out_ready_i;
    ob_d     = ob_q;
    st_d     = st_q;
    we       = 1'b0;
    waddr    = i_q;
    wdata    = sj_q;
    raddr    = i_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_RESTART: begin
              ov_d    = 1'b1;
              ob_d    = '0;
              st_d    = ST_OK;
              i_d     = '0;
              j_d     = '0;
              cnt_d   = '0;
              fill_d  = '0;
              state_d = S_FILL;
            end
            REQ_KEY: begin
              if (cnt_q[IdxW]) begin
                ov_d = 1'b1;
                ob_d = '0;
                st_d = ST_SURPLUS;
              end else begin
                key_d    = key_byte_i;
                is_key_d = 1'b1;
                raddr    = i_q;
                state_d  = S_RD_J;
              end
            end
            REQ_KSTREAM: begin
              if (!cnt_q[IdxW]) begin
                ov_d = 1'b1;
                ob_d = '0;
                st_d = ST_NOT_READY;
              end else begin
                is_key_d = 1'b0;
                i_d      = i_q + 1'b1;
                raddr    = i_q + 1'b1;
                state_d  = S_RD_J;
              end
            end
            REQ_READ: begin
              raddr   = entry_index_i;
              state_d = S_RD_X;
            end
            default: ;
          endcase
        end
      end
      S_FILL: begin
        we     = 1'b1;
        waddr  = fill_q;
        wdata  = fill_q;
        fill_d = fill_q + 1'b1;
        if (fill_q == IdxW'(TableSize - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_RD_J: begin
        si_d    = rdata;
        j_d     = j_new;
        raddr   = j_new;
        state_d = S_WR_I;
      end
      S_WR_I: begin
        sj_d    = rdata;
        we      = 1'b1;
        waddr   = i_q;
        wdata   = rdata;
        state_d = S_WR_J;
      end
      S_WR_J: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = si_q;
        if (is_key_q) begin
          cnt_d   = cnt_q + 1'b1;
          ov_d    = 1'b1;
          ob_d    = '0;
          st_d    = ST_OK;
          state_d = S_IDLE;
          if (cnt_q[IdxW-1:0] == IdxW'(TableSize - 1)) begin
            i_d = '0;
            j_d = '0;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          state_d = S_RD_T;
        end
      end
      S_RD_T: begin
        raddr   = si_q + sj_q;
        state_d = S_OUT_T;
      end
      S_OUT_T: begin
        ov_d    = 1'b1;
        ob_d    = rdata;
        st_d    = ST_OK;
        state_d = S_IDLE;
      end
      S_RD_X: begin
        ov_d    = 1'b1;
        ob_d    = rdata;
        st_d    = ST_OK;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_FILL;
      i_q      <= '0;
      j_q      <= '0;
      cnt_q    <= '0;
      fill_q   <= '0;
      is_key_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      j_q      <= j_d;
      cnt_q    <= cnt_d;
      fill_q   <= fill_d;
      is_key_q <= is_key_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q  <= si_d;
    sj_q  <= sj_d;
    key_q <= key_d;
    ob_q  <= ob_d;
    st_q  <= st_d;
  end

endmodule : rc4_keystream_generator_core
`default_nettype wire
